[src/dmo_pkg.sv]
// ----------------------------------------------------------------------------
// dmo_pkg: shared constants for the divided multiwave oscillator
// Field widths, fixed-point constants, register indexes and waveform codes.
// ----------------------------------------------------------------------------
package dmo_pkg;

  localparam int REF_W   = 17;
  localparam int MIX_W   = 24;
  localparam int VOL_W   = 17;
  localparam int OFF_W   = 17;
  localparam int DIVR_W  = 3;
  localparam int WAVE_W  = 2;
  localparam int PAN_W   = 18;
  localparam int LVL_W   = 18;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 18;

  typedef logic signed [LVL_W-1:0] lvl_t;

  localparam logic [REF_W-1:0] ONE     = 17'h10000;
  localparam lvl_t             LVL_ONE = 18'sh10000;
  localparam lvl_t             LVL_NEG = -18'sh10000;

  localparam logic signed [MIX_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [MIX_W-1:0] OUT_MIN = -24'sh800000;

  localparam logic [CFG_A_W-1:0] CFG_VOLUME = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_OFFSET = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_DIVIDER = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_WAVE   = 3'd3;
  localparam logic [CFG_A_W-1:0] CFG_PAN    = 3'd4;

  localparam logic [WAVE_W-1:0] WAVE_SAW = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_TRI = 2'd2;
  localparam logic [WAVE_W-1:0] WAVE_SQR = 2'd3;

endpackage

[src/dmo_div.sv]
// ----------------------------------------------------------------------------
// dmo_div: bit-serial restoring divider
// One quotient bit per cycle, narrow remainder against the small divider.
// ----------------------------------------------------------------------------
module dmo_div
  import dmo_pkg::*;
#(
  parameter int NUM_W = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DIVR_W-1:0] den,
  output logic              done,
  output logic [NUM_W-1:0]  quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [DIVR_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIVR_W:0]   trial;
  logic [DIVR_W:0]   diff;
  logic              ge;

  always_comb begin
    trial    = {rem_r, quo_r[NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = (trial >= {1'b0, den_r});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NUM_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      rem_nxt = ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[src/dmo_mul.sv]
// ----------------------------------------------------------------------------
// dmo_mul: bit-serial shift-add multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module dmo_mul #(
  parameter int MC_W = 18,
  parameter int MP_W = 18
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [MC_W-1:0]  mcand,
  input  logic [MP_W-1:0]         mplier,
  output logic                    done,
  output logic signed [MC_W+MP_W:0] prod
);

  localparam int CNT_W = (MP_W > 1) ? $clog2(MP_W) : 1;

  logic signed [MC_W-1:0] mc_r, mc_nxt;
  logic signed [MC_W:0]   acc_r, acc_nxt;
  logic [MP_W-1:0]        lo_r, lo_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [MC_W+1:0]        addend;
  logic [MC_W+1:0]        sum;

  always_comb begin
    addend   = lo_r[0] ? {{2{mc_r[MC_W-1]}}, mc_r} : '0;
    sum      = {acc_r[MC_W], acc_r} + addend;
    mc_nxt   = mc_r;
    acc_nxt  = acc_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      mc_nxt   = mcand;
      acc_nxt  = '0;
      lo_nxt   = mplier;
      cnt_nxt  = CNT_W'(MP_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // product bits shift out into the low half
      acc_nxt = sum[MC_W+1:1];
      lo_nxt  = {sum[0], lo_r[MP_W-1:1]};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mc_r  <= mc_nxt;
    acc_r <= acc_nxt;
    lo_r  <= lo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign prod = {acc_r, lo_r};

endmodule

[src/divided_multiwave_oscillator_unit.sv]
// ----------------------------------------------------------------------------
// divided_multiwave_oscillator_unit: divided sawtooth oscillator and mixer
// Each input transaction carries a reference sawtooth sample and a stereo mix
// sample pair. The block derives a divided sawtooth from the reference phase
// and wrap count, shapes it as sawtooth, triangle or square, scales it by
// volume, pans it and adds it to the mix with 24-bit saturation.
//
// Channels: in_* carries reference and left/right mix samples, out_* returns
// the mixed left/right pair, one output transaction per input transaction.
// cfg_* writes volume, phase offset, divider, waveform and pan; the user must
// write them only while idle, as the block itself does not enforce it.
// Timing: one transaction at a time. The phase step starts the serial
// divider, the shape step the volume multiply pass and the pan step the
// left and right pan multiply pass; the output step loads the output
// register, and only then is a new transaction accepted.
// The output register holds a result while out_tready is low; the next
// transaction is accepted meanwhile and waits in its last step.
// Reset sets the config registers to their defaults (volume 1.0, divider 1,
// sawtooth, centre pan) and clears the wrap count and previous phase.
// ----------------------------------------------------------------------------
module divided_multiwave_oscillator_unit
  import dmo_pkg::*;
#(
  parameter int MAX_DIVIDER = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [71:0]        in_tdata,   // reference[16:0], left_in[40:17], right_in[64:41]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [47:0]        out_tdata,  // left_out[23:0], right_out[47:24]
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0] cfg_wdata
);

  localparam int CW   = (MAX_DIVIDER > 1) ? $clog2(MAX_DIVIDER) : 1;
  localparam int NW   = 18 + CW;
  localparam int MP_W = 18;
  localparam int PR_W = LVL_W + MP_W + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PH    = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SHAPE = 3'd3;
  localparam logic [2:0] ST_MUL1  = 3'd4;
  localparam logic [2:0] ST_PAN   = 3'd5;
  localparam logic [2:0] ST_MUL2  = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [VOL_W-1:0]  volume_r;
  logic [OFF_W-1:0]  phase_offset_r;
  logic [DIVR_W-1:0] divider_r;
  logic [WAVE_W-1:0] waveform_r;
  logic signed [PAN_W-1:0] pan_r;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     period_count_r, period_count_nxt;
  logic [REF_W-1:0]  previous_phase_r, previous_phase_nxt;
  logic [REF_W-1:0]  ref_r, ref_nxt;
  logic signed [MIX_W-1:0] lin_r, lin_nxt, rin_r, rin_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [47:0]       out_data_r, out_data_nxt;

  logic [REF_W-1:0]  ref_in, ref_sat, off_sat, vol_sat, ph;
  logic [REF_W:0]    ph_sum;
  logic [DIVR_W-1:0] d_eff;
  logic [CW:0]       cnt_inc;
  logic [CW-1:0]     cnt_new;
  logic [NW-1:0]     dividend;
  logic              div_start, div_done;
  logic [NW-1:0]     quo;
  logic signed [REF_W+1:0] saw_ext, tri_ext;
  lvl_t              saw, saw_abs, wave;
  lvl_t              pan_sat;
  logic signed [LVL_W:0] l_gain_ext, r_gain_ext;
  logic              mul_a_start, mul_b_start, mul_a_done, mul_b_done;
  lvl_t              mul_a_mc;
  logic [MP_W-1:0]   mul_a_mp;
  logic signed [PR_W-1:0] prod_a, prod_b, rnd_v, rnd_l, rnd_r;
  lvl_t              vol_lvl, lpart, rpart;
  logic signed [MIX_W:0] l_sum, r_sum;
  logic signed [MIX_W-1:0] l_out, r_out;

  // config register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r       <= VOL_W'(ONE);
      phase_offset_r <= '0;
      divider_r      <= DIVR_W'(1);
      waveform_r     <= WAVE_SAW;
      pan_r          <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_VOLUME:  volume_r       <= cfg_wdata[VOL_W-1:0];
        CFG_OFFSET:  phase_offset_r <= cfg_wdata[OFF_W-1:0];
        CFG_DIVIDER: divider_r      <= cfg_wdata[DIVR_W-1:0];
        CFG_WAVE:    waveform_r     <= cfg_wdata[WAVE_W-1:0];
        CFG_PAN:     pan_r          <= $signed(cfg_wdata[PAN_W-1:0]);
        default: ;
      endcase
    end
  end

  // clamped settings
  always_comb begin
    ref_in  = in_tdata[REF_W-1:0];
    ref_sat = (ref_in > ONE) ? ONE : ref_in;
    off_sat = (phase_offset_r > ONE) ? ONE : phase_offset_r;
    vol_sat = (volume_r > ONE) ? ONE : volume_r;
    if (divider_r == '0) begin
      d_eff = DIVR_W'(1);
    end else if (int'(divider_r) > MAX_DIVIDER) begin
      d_eff = DIVR_W'(MAX_DIVIDER);
    end else begin
      d_eff = divider_r;
    end
    if (pan_r > LVL_ONE) begin
      pan_sat = LVL_ONE;
    end else if (pan_r < LVL_NEG) begin
      pan_sat = LVL_NEG;
    end else begin
      pan_sat = pan_r;
    end
    l_gain_ext = {LVL_ONE[LVL_W-1], LVL_ONE} - {pan_sat[LVL_W-1], pan_sat};
    r_gain_ext = {LVL_ONE[LVL_W-1], LVL_ONE} + {pan_sat[LVL_W-1], pan_sat};
  end

  // phase and wrap count
  always_comb begin
    ph_sum  = {1'b0, ref_r} + {1'b0, off_sat};
    ph      = (ph_sum > {1'b0, ONE}) ? REF_W'(ph_sum - {1'b0, ONE}) : ph_sum[REF_W-1:0];
    cnt_inc = {1'b0, period_count_r} + 1'b1;
    cnt_new = (int'(cnt_inc) >= int'(d_eff)) ? '0 : cnt_inc[CW-1:0];
    if (ph < previous_phase_r) begin
      period_count_nxt = cnt_new;
    end else begin
      period_count_nxt = period_count_r;
    end
    dividend = NW'({period_count_nxt, 17'b0}) + NW'({ph, 1'b0});
  end

  // waveform shaping from the quotient
  always_comb begin
    saw_ext = $signed({1'b0, quo[REF_W:0]}) - $signed({2'b00, ONE});
    if (quo > NW'(2 * int'(ONE))) begin
      saw = LVL_ONE;
    end else begin
      saw = saw_ext[LVL_W-1:0];
    end
    saw_abs = saw[LVL_W-1] ? -saw : saw;
    tri_ext = $signed({saw_abs, 1'b0}) - $signed({2'b00, ONE});
    case (waveform_r)
      WAVE_TRI: wave = tri_ext[LVL_W-1:0];
      WAVE_SQR: wave = (saw > 0) ? LVL_ONE : LVL_NEG;
      default:  wave = saw;
    endcase
  end

  // rounding and mixing
  always_comb begin
    rnd_v   = prod_a + PR_W'(32768);
    vol_lvl = rnd_v[33:16];
    rnd_l   = prod_a + PR_W'(65536);
    rnd_r   = prod_b + PR_W'(65536);
    lpart   = rnd_l[34:17];
    rpart   = rnd_r[34:17];
    l_sum   = {lin_r[MIX_W-1], lin_r} + (MIX_W+1)'(lpart);
    r_sum   = {rin_r[MIX_W-1], rin_r} + (MIX_W+1)'(rpart);
    if (l_sum[MIX_W] != l_sum[MIX_W-1]) begin
      l_out = l_sum[MIX_W] ? OUT_MIN : OUT_MAX;
    end else begin
      l_out = l_sum[MIX_W-1:0];
    end
    if (r_sum[MIX_W] != r_sum[MIX_W-1]) begin
      r_out = r_sum[MIX_W] ? OUT_MIN : OUT_MAX;
    end else begin
      r_out = r_sum[MIX_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt          = state_r;
    previous_phase_nxt = previous_phase_r;
    ref_nxt            = ref_r;
    lin_nxt            = lin_r;
    rin_nxt            = rin_r;
    out_valid_nxt      = out_valid_r;
    out_data_nxt       = out_data_r;
    div_start          = 1'b0;
    mul_a_start        = 1'b0;
    mul_b_start        = 1'b0;
    mul_a_mc           = wave;
    mul_a_mp           = MP_W'(vol_sat);
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ref_nxt   = ref_sat;
          lin_nxt   = $signed(in_tdata[40:17]);
          rin_nxt   = $signed(in_tdata[64:41]);
          state_nxt = ST_PH;
        end
      end
      ST_PH: begin
        previous_phase_nxt = ph;
        div_start          = 1'b1;
        state_nxt          = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_SHAPE;
        end
      end
      ST_SHAPE: begin
        mul_a_start = 1'b1;
        state_nxt   = ST_MUL1;
      end
      ST_MUL1: begin
        if (mul_a_done) begin
          state_nxt = ST_PAN;
        end
      end
      ST_PAN: begin
        mul_a_mc    = vol_lvl;
        mul_a_mp    = l_gain_ext[MP_W-1:0];
        mul_a_start = 1'b1;
        mul_b_start = 1'b1;
        state_nxt   = ST_MUL2;
      end
      ST_MUL2: begin
        if (mul_a_done && mul_b_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {r_out, l_out};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      period_count_r   <= '0;
      previous_phase_r <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      period_count_r   <= (state_r == ST_PH) ? period_count_nxt : period_count_r;
      previous_phase_r <= previous_phase_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ref_r      <= ref_nxt;
    lin_r      <= lin_nxt;
    rin_r      <= rin_nxt;
    out_data_r <= out_data_nxt;
  end

  dmo_div #(
    .NUM_W (NW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (dividend),
    .den   (d_eff),
    .done  (div_done),
    .quo   (quo)
  );

  dmo_mul #(
    .MC_W (LVL_W),
    .MP_W (MP_W)
  ) u_mul_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_a_start),
    .mcand  (mul_a_mc),
    .mplier (mul_a_mp),
    .done   (mul_a_done),
    .prod   (prod_a)
  );

  dmo_mul #(
    .MC_W (LVL_W),
    .MP_W (MP_W)
  ) u_mul_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_b_start),
    .mcand  (vol_lvl),
    .mplier (r_gain_ext[MP_W-1:0]),
    .done   (mul_b_done),
    .prod   (prod_b)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
